### sv/mbd_pkg.sv
// Package for the Moran birth-death grid step block: payload structs,
// controller states and the controller-to-datapath command struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mbd_pkg;

  typedef struct packed {
    logic        req_type;
    logic [15:0] coin;
    logic [15:0] pick;
    logic [1:0]  direction;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [8:0] mutant_count;
    logic [7:0] last_converted;
  } rsp_t;

  localparam logic [1:0] STATUS_RUNNING  = 2'd0;
  localparam logic [1:0] STATUS_FIXATION = 2'd1;
  localparam logic [1:0] STATUS_EXTINCT  = 2'd2;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam logic [1:0] REG_FITNESS = 2'd0;
  localparam logic [1:0] REG_ALWAYS  = 2'd1;
  localparam logic [1:0] REG_START   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_MUL,
    ST_CMP,
    ST_PICK,
    ST_READ_B,
    ST_READ_D,
    ST_READ_LAST,
    ST_WRITE_A,
    ST_WRITE_B,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic init_step;
    logic mul;
    logic cmp;
    logic pick;
    logic read_b;
    logic read_d;
    logic read_last;
    logic write_a;
    logic write_b;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic running;
    logic is_start;
  } sts_t;

endpackage
`default_nettype wire

### sv/mbd_ctrl.sv
// Controller state machine for the Moran birth-death grid step block.
// Depends on mbd_pkg for the state enum and command and status structs.
`timescale 1ns / 1ps
`default_nettype none
module mbd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire mbd_pkg::sts_t sts,
  output mbd_pkg::cmd_t      cmd
);

  mbd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    case (state)
      mbd_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          state_next = mbd_pkg::ST_MUL;
        end
      end
      mbd_pkg::ST_MUL: begin
        if (sts.is_start) begin
          state_next = mbd_pkg::ST_INIT;
        end else if (!sts.running) begin
          state_next = mbd_pkg::ST_DONE;
        end else begin
          cmd.mul = 1'b1;
          state_next = mbd_pkg::ST_CMP;
        end
      end
      mbd_pkg::ST_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_last) begin
          state_next = mbd_pkg::ST_DONE;
        end
      end
      mbd_pkg::ST_CMP: begin
        cmd.cmp = 1'b1;
        state_next = mbd_pkg::ST_PICK;
      end
      mbd_pkg::ST_PICK: begin
        cmd.pick = 1'b1;
        state_next = mbd_pkg::ST_READ_B;
      end
      mbd_pkg::ST_READ_B: begin
        cmd.read_b = 1'b1;
        state_next = mbd_pkg::ST_READ_D;
      end
      mbd_pkg::ST_READ_D: begin
        cmd.read_d = 1'b1;
        state_next = mbd_pkg::ST_READ_LAST;
      end
      mbd_pkg::ST_READ_LAST: begin
        cmd.read_last = 1'b1;
        state_next = mbd_pkg::ST_WRITE_A;
      end
      mbd_pkg::ST_WRITE_A: begin
        cmd.write_a = 1'b1;
        state_next = mbd_pkg::ST_WRITE_B;
      end
      mbd_pkg::ST_WRITE_B: begin
        cmd.write_b = 1'b1;
        state_next = mbd_pkg::ST_DONE;
      end
      mbd_pkg::ST_DONE: begin
        cmd.finish = 1'b1;
        state_next = mbd_pkg::ST_IDLE;
      end
      default: begin
        state_next = mbd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### sv/mbd_datapath.sv
// Datapath for the Moran birth-death grid step block: type map, lists,
// position store, population choice and swap-remove updates. Depends on mbd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mbd_datapath #(
  parameter int ROWS = 16,
  parameter int COLS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mbd_pkg::req_t req,
  input  wire mbd_pkg::cmd_t cmd,
  input  wire logic [15:0]   fitness_r,
  input  wire logic          always_mutant_births,
  input  wire logic [7:0]    start_vertex,
  output mbd_pkg::sts_t      sts,
  output logic               result_valid,
  output mbd_pkg::rsp_t      result
);

  localparam int NV  = ROWS * COLS;
  localparam int VW  = $clog2(NV);
  localparam int CW  = $clog2(NV + 1);
  localparam int RW  = $clog2(ROWS);
  localparam int CLW = $clog2(COLS);

  // The row of a vertex comes from a reciprocal multiply. With vertex numbers
  // below 4096 the error stays under 1/256, which is smaller than 1/COLS, so
  // the truncated product equals the exact quotient.
  localparam int DIV_SHIFT = 20;
  localparam int DIV_MULT  = (1 << DIV_SHIFT) / COLS + 1;

  // Per-vertex mutant flags; a start item rewrites every entry.
  logic mutant_map [NV];
  logic [VW-1:0] mutant_list [NV];
  logic [VW-1:0] resident_list [NV];
  logic [VW-1:0] list_position [NV];

  logic [CW-1:0] mutant_total;
  logic [VW-1:0] recent_convert;
  logic          trial_running;

  mbd_pkg::req_t   held;
  logic [VW-1:0]   init_v;
  logic [VW-1:0]   init_n;
  logic [VW-1:0]   v0;
  logic [CW+15:0]  rk;
  logic [CW+15:0]  denom;
  logic            mut;
  logic [VW-1:0]   idx;
  logic [VW-1:0]   b;
  logic [VW-1:0]   d;
  logic            b_mut;
  logic            d_mut;
  logic [VW-1:0]   pos_d;
  logic [VW-1:0]   last;
  logic [CW-1:0]   size;

  logic [CW+15:0]  rk_w;
  logic [CW+15:0]  denom_w;
  logic [CW+31:0]  lhs;
  logic [CW+31:0]  rhs;
  logic [CW+15:0]  pick_prod;
  logic [CW-1:0]   res_cnt;
  logic [31:0]     row_prod;
  logic [RW-1:0]   brow;
  logic [CLW-1:0]  bcol;
  logic [RW-1:0]   drow;
  logic [CLW-1:0]  dcol;

  assign res_cnt = CW'(NV) - mutant_total;
  assign rk_w    = (CW+16)'(fitness_r) * (CW+16)'(mutant_total);
  assign denom_w = ((CW+16)'(res_cnt) << 8) + rk_w;
  assign lhs     = (CW+32)'(held.coin) * (CW+32)'(denom);
  assign rhs     = (CW+32)'(rk) << 16;
  assign pick_prod = (CW+16)'(held.pick) * (CW+16)'(size);
  assign row_prod  = 32'(b) * 32'(DIV_MULT);

  always_comb begin
    brow = RW'(row_prod >> DIV_SHIFT);
    bcol = CLW'(32'(b) - 32'(brow) * 32'(COLS));
    drow = brow;
    dcol = bcol;
    case (held.direction)
      mbd_pkg::DIR_UP:    drow = (brow == '0) ? RW'(ROWS - 1) : brow - 1'b1;
      mbd_pkg::DIR_DOWN:  drow = (32'(brow) == ROWS - 1) ? '0 : brow + 1'b1;
      mbd_pkg::DIR_LEFT:  dcol = (bcol == '0) ? CLW'(COLS - 1) : bcol - 1'b1;
      default:            dcol = (32'(bcol) == COLS - 1) ? '0 : bcol + 1'b1;
    endcase
  end

  assign sts.init_last = (32'(init_v) == NV - 1);
  assign sts.running   = trial_running;
  assign sts.is_start  = !held.req_type;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      held <= req;
      init_v <= '0;
      init_n <= '0;
      v0 <= (32'(start_vertex) >= NV) ? VW'(NV - 1) : VW'(start_vertex);
    end
    if (cmd.init_step) begin
      mutant_map[init_v] <= (init_v == v0);
      if (init_v == v0) begin
        mutant_list[0] <= init_v;
        list_position[init_v] <= '0;
      end else begin
        resident_list[init_n] <= init_v;
        list_position[init_v] <= init_n;
        init_n <= init_n + 1'b1;
      end
      init_v <= init_v + 1'b1;
    end
    if (cmd.mul) begin
      rk <= rk_w;
      denom <= denom_w;
    end
    if (cmd.cmp) begin
      mut <= always_mutant_births || (lhs < rhs);
      size <= (always_mutant_births || (lhs < rhs)) ? mutant_total : res_cnt;
    end
    if (cmd.pick) begin
      idx <= VW'(pick_prod >> 16);
    end
    if (cmd.read_b) begin
      b <= mut ? mutant_list[idx] : resident_list[idx];
    end
    if (cmd.read_d) begin
      b_mut <= mutant_map[b];
      d <= VW'(32'(drow) * COLS + 32'(dcol));
    end
    if (cmd.read_last) begin
      d_mut <= mutant_map[d];
      pos_d <= list_position[d];
      if (b_mut) begin
        last <= resident_list[VW'(res_cnt - 1'b1)];
      end else begin
        last <= mutant_list[VW'(mutant_total - 1'b1)];
      end
    end
    if (cmd.write_a && (b_mut != d_mut)) begin
      if (b_mut) begin
        resident_list[pos_d] <= last;
      end else begin
        mutant_list[pos_d] <= last;
      end
      list_position[last] <= pos_d;
    end
    if (cmd.write_b && (b_mut != d_mut)) begin
      mutant_map[d] <= b_mut;
      if (b_mut) begin
        mutant_list[VW'(mutant_total)] <= d;
        list_position[d] <= VW'(mutant_total);
      end else begin
        resident_list[VW'(res_cnt)] <= d;
        list_position[d] <= VW'(res_cnt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mutant_total <= '0;
      recent_convert <= '0;
      trial_running <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.finish;
      if (cmd.init_step && sts.init_last) begin
        mutant_total <= CW'(1);
        recent_convert <= v0;
        trial_running <= (NV > 1);
      end
      if (cmd.write_b && (b_mut != d_mut)) begin
        if (b_mut) begin
          mutant_total <= mutant_total + 1'b1;
          recent_convert <= d;
          if (32'(mutant_total) + 1 >= NV) begin
            trial_running <= 1'b0;
          end
        end else begin
          mutant_total <= mutant_total - 1'b1;
          if (mutant_total == CW'(1)) begin
            trial_running <= 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    if (mutant_total == '0) begin
      result.status = mbd_pkg::STATUS_EXTINCT;
    end else if (32'(mutant_total) >= NV) begin
      result.status = mbd_pkg::STATUS_FIXATION;
    end else begin
      result.status = mbd_pkg::STATUS_RUNNING;
    end
    result.mutant_count   = 9'(mutant_total);
    result.last_converted = 8'(recent_convert);
  end

endmodule
`default_nettype wire

### sv/moran_birth_death_grid_step_top.sv
// Top level of the Moran birth-death grid step block: APB register file,
// controller and datapath. Depends on mbd_pkg, mbd_ctrl and mbd_datapath.
//
//   Channel   Handshake              Payload
//   request   start / busy           req (req_type, coin, pick, direction)
//   result    done (one-cycle word)  rsp (status, mutant_count, last_converted)
//   config    APB psel/penable       paddr, pwdata, prdata
//
// An event word's result waits on the chain of dependent reads and writes
// on the list and map stores. An event arriving while no trial runs skips
// that chain and goes straight to the finishing step. A start word walks
// every vertex once before its result.
// Reset clears the trial state, the controller and the registers to their
// defaults. The receiver cannot stall: each result word is shown for exactly
// one cycle. busy is high from the cycle after acceptance up to the strobe
// cycle, where it drops so the next word can be taken alongside the strobe.
`timescale 1ns / 1ps
`default_nettype none
module moran_birth_death_grid_step_top #(
  parameter int ROWS = 16,
  parameter int COLS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire mbd_pkg::req_t req,
  output logic               done,
  output mbd_pkg::rsp_t      rsp,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [15:0] fitness_r;
  logic        always_mutant_births;
  logic [7:0]  start_vertex;
  logic        wr_en;

  mbd_pkg::cmd_t cmd;
  mbd_pkg::sts_t sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Registers are word aligned; the low two address bits are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      fitness_r <= 16'd256;
      always_mutant_births <= 1'b0;
      start_vertex <= 8'd0;
    end else if (wr_en) begin
      case (paddr[3:2])
        mbd_pkg::REG_FITNESS: fitness_r <= pwdata[15:0];
        mbd_pkg::REG_ALWAYS:  always_mutant_births <= pwdata[0];
        mbd_pkg::REG_START:   start_vertex <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      mbd_pkg::REG_FITNESS: prdata = {16'd0, fitness_r};
      mbd_pkg::REG_ALWAYS:  prdata = {31'd0, always_mutant_births};
      mbd_pkg::REG_START:   prdata = {24'd0, start_vertex};
      default:              prdata = '0;
    endcase
  end

  mbd_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .sts  (sts),
    .cmd  (cmd)
  );

  mbd_datapath #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .req                 (req),
    .cmd                 (cmd),
    .fitness_r           (fitness_r),
    .always_mutant_births(always_mutant_births),
    .start_vertex        (start_vertex),
    .sts                 (sts),
    .result_valid        (done),
    .result              (rsp)
  );

  // The result strobe comes in the cycle after the finishing step.
  assert property (@(posedge clk) disable iff (rst) cmd.finish |=> done)
    else $error("result strobe missing after finish");

  // No strobe is shown right after a new word is accepted by the idle controller.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> !done)
    else $error("result strobe overlaps acceptance");

  // The mutant count never exceeds the vertex count.
  assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(rsp.mutant_count) <= ROWS * COLS))
    else $error("mutant count out of range");

endmodule
`default_nettype wire
